FILE: rtl/core/hpr_pkg.sv
`timescale 1ns / 1ps

package hpr_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_W = 16;

  localparam logic [14:0] SUM_MAX   = 15'h7fff;
  localparam logic [7:0]  DUTY_HIGH = 8'd75;
  localparam logic [7:0]  DUTY_LOW  = 8'd25;
  localparam logic [7:0]  DUTY_MAX  = 8'd255;

  localparam logic signed [8:0] TARGET_RST    = 9'sd0;
  localparam logic [15:0]       PROP_GAIN_RST = 16'd896;
  localparam logic [15:0]       INT_GAIN_RST  = 16'd328;
  localparam logic [6:0]        DEAD_BAND_RST = 7'd3;

  typedef enum logic [1:0] {
    CFG_TARGET_HEADING = 2'd0,
    CFG_PROP_GAIN      = 2'd1,
    CFG_INT_GAIN       = 2'd2,
    CFG_DEAD_BAND      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [8:0] target_heading;
    logic [15:0]       prop_gain_q8;
    logic [15:0]       int_gain_q16;
    logic [6:0]        dead_band;
  } cfg_t;

  typedef struct packed {
    logic signed [9:0] heading_error;
    logic [8:0]        err_mag;
    logic [14:0]       error_sum;
    logic              drive_active;
    logic              rotate_ccw;
  } item_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/core/hpr_front.sv
`timescale 1ns / 1ps

module hpr_front import hpr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_push,
  input  logic signed [8:0] in_heading,
  input  q_stat_t           q_stat,
  output logic              in_full,
  output logic              q_wr,
  output item_t             q_item
);

  logic [14:0]       error_sum_r;
  logic [14:0]       error_sum_nxt;
  logic signed [9:0] err;
  logic [9:0]        err_neg;
  logic [8:0]        mag;
  logic [15:0]       sum_wide;

  assign in_full = q_stat.full;
  assign q_wr    = in_push && !q_stat.full;

  always_comb begin
    err      = {cfg.target_heading[8], cfg.target_heading} - {in_heading[8], in_heading};
    err_neg  = -err;
    mag      = err[9] ? err_neg[8:0] : err[8:0];
    sum_wide = {1'b0, error_sum_r} + {7'b0, mag};
    if (err == 10'sd0) begin
      error_sum_nxt = 15'd0;
    end else if (sum_wide[15]) begin
      error_sum_nxt = SUM_MAX;
    end else begin
      error_sum_nxt = sum_wide[14:0];
    end
  end

  always_comb begin
    q_item.heading_error = err;
    q_item.err_mag       = mag;
    q_item.error_sum     = error_sum_nxt;
    q_item.drive_active  = mag > {2'b0, cfg.dead_band};
    q_item.rotate_ccw    = !err[9];
  end

  // advance the integral on every accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r <= 15'd0;
    end else if (q_wr) begin
      error_sum_r <= error_sum_nxt;
    end
  end

endmodule

FILE: rtl/core/hpr_queue.sv
`timescale 1ns / 1ps

module hpr_queue import hpr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_ctl_t  ctl,
  input  item_t   wr_item,
  output q_stat_t stat,
  output item_t   rd_item
);

  item_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic [QCNT_W-1:0]  count_nxt;

  assign stat.full  = count_r == QCNT_W'(QDEPTH);
  assign stat.empty = count_r == '0;
  assign rd_item    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (ctl.wr && !ctl.rd) begin
      count_nxt = count_r + 1'b1;
    end else if (!ctl.wr && ctl.rd) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (ctl.wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (ctl.rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_rd_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd |-> !stat.empty)
    else $error("queue read while empty");

  a_wr_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.wr && !ctl.rd) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on write");

endmodule

FILE: rtl/core/hpr_back.sv
`timescale 1ns / 1ps

module hpr_back import hpr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              q_empty,
  input  item_t             q_item,
  output logic              q_rd,
  input  logic              out_pop,
  output logic              out_empty,
  output logic              out_drive_active,
  output logic              out_rotate_ccw,
  output logic [7:0]        out_left_duty,
  output logic [7:0]        out_right_duty,
  output logic signed [9:0] out_heading_error
);

  logic        s1_valid_r;
  item_t       s1_item_r;
  logic [24:0] s1_pprod_r;
  logic [30:0] s1_iprod_r;
  logic        out_valid_r;
  logic        s2_ld;
  logic [33:0] acc;
  logic [17:0] corr;
  logic [18:0] hi_sum;
  logic [18:0] lo_sum;
  logic [7:0]  hi_duty;
  logic [7:0]  lo_duty;

  assign out_empty = !out_valid_r;
  assign s2_ld     = s1_valid_r && (!out_valid_r || out_pop);
  assign q_rd      = !q_empty && (!s1_valid_r || s2_ld);

  always_comb begin
    acc     = {1'b0, s1_pprod_r, 8'b0} + {3'b0, s1_iprod_r};
    corr    = acc[33:16];
    hi_sum  = {11'b0, DUTY_HIGH} + {1'b0, corr};
    lo_sum  = {11'b0, DUTY_LOW} + {1'b0, corr};
    hi_duty = (hi_sum > {11'b0, DUTY_MAX}) ? DUTY_MAX : hi_sum[7:0];
    lo_duty = (lo_sum > {11'b0, DUTY_MAX}) ? DUTY_MAX : lo_sum[7:0];
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      s1_item_r  <= q_item;
      s1_pprod_r <= 25'(q_item.err_mag) * 25'(cfg.prop_gain_q8);
      s1_iprod_r <= 31'(q_item.error_sum) * 31'(cfg.int_gain_q16);
    end
    if (s2_ld) begin
      out_heading_error <= s1_item_r.heading_error;
      out_drive_active  <= s1_item_r.drive_active;
      if (!s1_item_r.drive_active) begin
        out_rotate_ccw <= 1'b0;
        out_left_duty  <= 8'd0;
        out_right_duty <= 8'd0;
      end else if (s1_item_r.rotate_ccw) begin
        out_rotate_ccw <= 1'b1;
        out_left_duty  <= lo_duty;
        out_right_duty <= hi_duty;
      end else begin
        out_rotate_ccw <= 1'b0;
        out_left_duty  <= hi_duty;
        out_right_duty <= lo_duty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_rd) begin
        s1_valid_r <= 1'b1;
      end else if (s2_ld) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_drive_active) |->
      (out_left_duty == 8'd0 && out_right_duty == 8'd0 && !out_rotate_ccw))
    else $error("duty driven inside deadband");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ld) |=> s1_valid_r && $stable(s1_pprod_r) && $stable(s1_iprod_r))
    else $error("stalled product stage lost its beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty && $stable(out_left_duty))
    else $error("waiting result dropped");

endmodule

FILE: rtl/core/heading_pi_rotate_controller.sv
`timescale 1ns / 1ps

// Heading PI rotate controller. Each heading sample pushed in gives one result
// with error = target - heading, a rotate command and two PWM duties of
// 75/25 plus a PI correction (|error| * Q8.8 kp plus Q0.16 ki * integral,
// fraction truncated, duties capped at 255); inside the deadband no drive is
// issued but the error and integral still update. One sample is taken every
// clock while the queue is not full. The front stage updates the integral and
// classifies the sample, a four-entry queue decouples it from a two-stage
// multiply/saturate back end, and the last stage holds the result until popped.
// Write registers only while no beat is in flight.
module heading_pi_rotate_controller import hpr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_push,
  input  logic signed [8:0] in_heading,
  output logic              in_full,
  input  logic              out_pop,
  output logic              out_empty,
  output logic              out_drive_active,
  output logic              out_rotate_ccw,
  output logic [7:0]        out_left_duty,
  output logic [7:0]        out_right_duty,
  output logic signed [9:0] out_heading_error
);

  cfg_t    cfg_r;
  q_ctl_t  q_ctl;
  q_stat_t q_stat;
  item_t   q_wr_item;
  item_t   q_rd_item;
  logic    q_wr;
  logic    q_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_heading <= TARGET_RST;
      cfg_r.prop_gain_q8   <= PROP_GAIN_RST;
      cfg_r.int_gain_q16   <= INT_GAIN_RST;
      cfg_r.dead_band      <= DEAD_BAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_TARGET_HEADING: cfg_r.target_heading <= cfg_wdata[8:0];
        CFG_PROP_GAIN:      cfg_r.prop_gain_q8   <= cfg_wdata;
        CFG_INT_GAIN:       cfg_r.int_gain_q16   <= cfg_wdata;
        CFG_DEAD_BAND:      cfg_r.dead_band      <= cfg_wdata[6:0];
        default: begin
        end
      endcase
    end
  end

  assign q_ctl.wr = q_wr;
  assign q_ctl.rd = q_rd;

  hpr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_push    (in_push),
    .in_heading (in_heading),
    .q_stat     (q_stat),
    .in_full    (in_full),
    .q_wr       (q_wr),
    .q_item     (q_wr_item)
  );

  hpr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (q_ctl),
    .wr_item (q_wr_item),
    .stat    (q_stat),
    .rd_item (q_rd_item)
  );

  hpr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_stat.empty),
    .q_item            (q_rd_item),
    .q_rd              (q_rd),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_drive_active  (out_drive_active),
    .out_rotate_ccw    (out_rotate_ccw),
    .out_left_duty     (out_left_duty),
    .out_right_duty    (out_right_duty),
    .out_heading_error (out_heading_error)
  );

endmodule
